// File: hdl/tcp_out_of_order_reassembly_unit_assert.svh
// Assertion macros used by the reassembly unit checker
`ifndef TCP_OUT_OF_ORDER_REASSEMBLY_UNIT_ASSERT_SVH
`define TCP_OUT_OF_ORDER_REASSEMBLY_UNIT_ASSERT_SVH
// Implication checked on every clock, disabled in reset
`define TOR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define TOR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hdl/tor_pkg.sv
// Shared constants and types of the reassembly unit
package tor_pkg;
   localparam int RING_BYTES = 4096;
   localparam int PTR_W = $clog2(RING_BYTES);
   localparam int CNT_W = PTR_W + 1;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0, KIND_DISCARD = 2'd1, KIND_READ = 2'd2, KIND_OPEN = 2'd3
   } kind_type;

   typedef struct packed {
      logic latch_req;    // capture request fields
      logic probe_place;  // read presence bit at placement slot
      logic write_byte;   // conditional byte write at placement slot
      logic scan_step;    // consume tail bit if present
      logic clr_step;     // clear bit at sweep pointer, advance
      logic clr_init_disc;
      logic clr_init_open;
      logic read_issue;   // read ring head
      logic do_open;
      logic load_rsp;
   } tor_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     in_window;
      logic     tail_present;
      logic     full;
      logic     clr_done;
      logic     empty;
   } tor_sts_type;
endpackage

// File: hdl/tor_datapath.sv
// Datapath: ring store, presence bitmap, pointers and result register
module tor_datapath import tor_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_seq,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  tor_cmd_type cmd,
   output tor_sts_type sts,
   output logic [12:0] rsp_advanced,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_status,
   output logic [31:0] rsp_expected_seq,
   output logic [12:0] rsp_ready_count
);
   logic [7:0] ring_mem [RING_BYTES];
   logic       pres_mem [RING_BYTES];

   logic [1:0]  kind_ff;
   logic [31:0] seq_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      nseq_ff, nseq_in;
   logic [CNT_W-1:0] adv_ff, adv_in;
   logic [PTR_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0] clr_left_ff, clr_left_in;
   logic             rfail_ff, rfail_in;

   logic [PTR_W-1:0] tail;
   logic [31:0]      diff;
   logic [CNT_W-1:0] window;
   logic             in_win;
   logic [PTR_W-1:0] place;
   logic [PTR_W-1:0] addr;
   logic             pres_rd_ff;
   logic [7:0]       byte_rd;

   assign tail   = head_ff + count_ff[PTR_W-1:0];
   assign diff   = seq_ff - nseq_ff;
   assign window = CNT_W'(RING_BYTES) - count_ff;
   assign in_win = !diff[31] && (diff < 32'(window));
   assign place  = tail + diff[PTR_W-1:0];

   // Single bitmap address per cycle, chosen by command
   always_comb begin
      addr = tail;
      if (cmd.probe_place || cmd.write_byte) addr = place;
      else if (cmd.clr_step) addr = clr_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte && in_win && !pres_rd_ff) ring_mem[place] <= data_ff;
      if (cmd.read_issue) byte_rd <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      pres_rd_ff <= pres_mem[addr];
      if (cmd.write_byte && in_win) pres_mem[addr] <= 1'b1;
      else if ((cmd.scan_step && !count_ff[PTR_W]) || cmd.clr_step) pres_mem[addr] <= 1'b0;
   end

   always_comb begin
      head_in = head_ff; count_in = count_ff; nseq_in = nseq_ff; adv_in = adv_ff;
      clr_ptr_in = clr_ptr_ff; clr_left_in = clr_left_ff; rfail_in = rfail_ff;
      if (cmd.latch_req) begin
         adv_in = '0;
         rfail_in = 1'b0;
      end
      if (cmd.scan_step && pres_rd_ff && !count_ff[PTR_W]) begin
         count_in = count_ff + 1'b1;
         nseq_in  = nseq_ff + 32'd1;
         adv_in   = adv_ff + 1'b1;
      end
      if (cmd.clr_init_disc) begin
         clr_ptr_in  = place;
         clr_left_in = window - diff[CNT_W-1:0];
      end
      if (cmd.clr_init_open) begin
         clr_ptr_in  = '0;
         clr_left_in = CNT_W'(RING_BYTES);
         nseq_in = seq_ff; head_in = '0; count_in = '0;
      end
      if (cmd.clr_step) begin
         clr_ptr_in  = clr_ptr_ff + 1'b1;
         clr_left_in = clr_left_ff - 1'b1;
      end
      if (cmd.read_issue) begin
         if (count_ff == '0) rfail_in = 1'b1;
         else begin
            head_in = head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; count_ff <= '0; nseq_ff <= '0;
         clr_ptr_ff <= '0; clr_left_ff <= CNT_W'(RING_BYTES);
      end else begin
         head_ff <= head_in; count_ff <= count_in; nseq_ff <= nseq_in;
         clr_ptr_ff <= clr_ptr_in; clr_left_ff <= clr_left_in;
      end
   end

   always_ff @(posedge clock) begin
      adv_ff <= adv_in; rfail_ff <= rfail_in;
      if (cmd.latch_req) begin
         kind_ff <= req_kind; seq_ff <= req_seq;
         data_ff <= req_data_byte; last_ff <= req_last_byte;
      end
      if (cmd.load_rsp) begin
         rsp_advanced     <= 13'(adv_ff);
         rsp_read_byte    <= (kind_ff == KIND_READ && !rfail_ff) ? byte_rd : 8'd0;
         rsp_status       <= (kind_ff == KIND_READ) && rfail_ff;
         rsp_expected_seq <= nseq_ff;
         rsp_ready_count  <= 13'(count_ff);
      end
   end

   assign sts.kind         = kind_type'(kind_ff);
   assign sts.last         = last_ff;
   assign sts.in_window    = in_win;
   assign sts.tail_present = pres_rd_ff;
   assign sts.full         = count_ff[PTR_W];
   assign sts.clr_done     = (clr_left_ff == '0);
   assign sts.empty        = (count_ff == '0);
endmodule

// File: hdl/tor_control.sv
// Controller: sequences each transaction through the datapath
module tor_control import tor_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  tor_sts_type sts,
   output tor_cmd_type cmd
);
   typedef enum logic [8:0] {
      ST_INIT    = 9'b000000001, ST_IDLE  = 9'b000000010, ST_DECODE = 9'b000000100,
      ST_PLACE   = 9'b000001000, ST_SCAN_RD = 9'b000010000, ST_SCAN = 9'b000100000,
      ST_CLEAR   = 9'b001000000, ST_READ  = 9'b010000000, ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;
   logic      can_load;

   assign rsp_valid = rv_ff;
   assign can_load  = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rv_in = rv_ff && rsp_stall;
      case (state_ff)
         ST_INIT: begin
            // sweep the whole bitmap once after reset
            if (sts.clr_done) state_in = ST_IDLE;
            else cmd.clr_step = 1'b1;
         end
         ST_IDLE: if (req_valid) begin
            cmd.latch_req = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (sts.kind)
               KIND_BYTE: begin
                  cmd.probe_place = 1'b1;
                  state_in = ST_PLACE;
               end
               KIND_DISCARD: begin
                  cmd.clr_init_disc = sts.in_window;
                  state_in = sts.in_window ? ST_CLEAR : ST_DONE;
               end
               KIND_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in = ST_READ;
               end
               default: begin
                  cmd.clr_init_open = 1'b1;
                  state_in = ST_CLEAR;
               end
            endcase
         end
         ST_PLACE: begin
            cmd.write_byte = 1'b1;
            state_in = sts.last ? ST_SCAN_RD : ST_DONE;
         end
         // fetch the tail bit, then consume it
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.full || !sts.tail_present) state_in = ST_DONE;
            else state_in = ST_SCAN_RD;
         end
         ST_CLEAR: begin
            if (sts.clr_done) state_in = ST_DONE;
            else cmd.clr_step = 1'b1;
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (can_load) begin
            cmd.load_rsp = 1'b1;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end
endmodule

// File: hdl/tcp_out_of_order_reassembly_unit.sv
// Top level of the TCP out-of-order reassembly unit
// One transaction in flight at a time. A segment byte is decoded, its
// placement slot probed and the byte written; when it is a last byte a scan
// follows that fetches each tail bit, then consumes it, for every byte made
// contiguous. A read is decoded and the ring head read; a discard outside the
// window goes straight to its result, else it clears each window slot from its
// own onward; an open clears the whole bitmap. A stalled result holds the unit
// in its done state, and the next request is taken only once the result is
// loaded. After reset the bitmap is swept once before the first request is taken.
// The bitmap has one port with a registered read.
module tcp_out_of_order_reassembly_unit import tor_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_seq,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_advanced,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_status,
   output logic [31:0] rsp_expected_seq,
   output logic [12:0] rsp_ready_count
);
   tor_cmd_type cmd;
   tor_sts_type sts;

   tor_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   tor_datapath u_datapath (
      .clock, .reset, .req_kind, .req_seq, .req_data_byte, .req_last_byte,
      .cmd, .sts, .rsp_advanced, .rsp_read_byte, .rsp_status,
      .rsp_expected_seq, .rsp_ready_count
   );
endmodule

// File: hdl/tor_checker.sv
// Port-level checker for the reassembly unit, bound to the top level
`include "tcp_out_of_order_reassembly_unit_assert.svh"
module tor_checker import tor_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [12:0] rsp_advanced,
   input logic [7:0]  rsp_read_byte,
   input logic        rsp_status,
   input logic [12:0] rsp_ready_count
);
   `TOR_ASSERT_IMP(a_rdy_bound, clock, reset, rsp_valid, rsp_ready_count <= 13'(RING_BYTES), "ready count beyond ring")
   `TOR_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_status, rsp_read_byte == 8'd0 && rsp_advanced == 13'd0 && rsp_ready_count == 13'd0, "failed read with data")
   `TOR_ASSERT_NEXT(a_one_flight, clock, reset, req_valid && !req_stall, req_stall, "second transaction taken while busy")
   `TOR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_advanced), "stalled result changed")
endmodule

bind tcp_out_of_order_reassembly_unit tor_checker u_tor_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_advanced, .rsp_read_byte, .rsp_status, .rsp_ready_count
);
